// File: hw/rtl/pfb_pkg.sv
package pfb_pkg;

    localparam int PIXEL_COUNT = 65536;
    localparam int ADDR_W      = $clog2(PIXEL_COUNT);
    localparam int PIX_W       = 4;
    localparam int BUS_ADDR_W  = 16;
    localparam int BUS_SPACE   = 2 ** BUS_ADDR_W;

    // compare-subtract steps that bring a 16-bit address below PIXEL_COUNT
    localparam int RED_STEPS   = $clog2((BUS_SPACE + PIXEL_COUNT - 1) / PIXEL_COUNT);

    localparam logic [7:0] DEV_SEL_CODE = 8'h02;
    localparam int         RUN_W        = 4;
    localparam int         COLOR_SHIFT  = 12;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 24;

    typedef logic [ADDR_W-1:0] pix_addr_t;
    typedef logic [PIX_W-1:0]  pix_t;
    typedef logic [23:0]       rgb_t;

    localparam rgb_t PALETTE [16] = '{
        24'h000000, 24'h444444, 24'h000088, 24'h4444BB,
        24'h008800, 24'h44BB44, 24'h008888, 24'h44BBBB,
        24'h880000, 24'hBB4444, 24'h880088, 24'hBB44BB,
        24'h888800, 24'hBB44BB, 24'h888888, 24'hBBBBBB
    };

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_PREP  = 5'b00100,
        ST_FILL  = 5'b01000,
        ST_RD    = 5'b10000
    } state_t;

    // bus address modulo PIXEL_COUNT
    function automatic pix_addr_t reduce_addr(input logic [BUS_ADDR_W-1:0] x);
        logic [BUS_ADDR_W:0] r;
        logic [BUS_ADDR_W:0] m;
        r = {1'b0, x};
        for (int s = RED_STEPS - 1; s >= 0; s--)
        begin
            m = (BUS_ADDR_W + 1)'(PIXEL_COUNT) << s;
            if (r >= m)
            begin
                r = r - m;
            end
        end
        return r[ADDR_W-1:0];
    endfunction

    function automatic pix_addr_t next_addr(input pix_addr_t a);
        pix_addr_t n;
        if (a == ADDR_W'(PIXEL_COUNT - 1))
        begin
            n = '0;
        end
        else
        begin
            n = a + 1'b1;
        end
        return n;
    endfunction

endpackage

// File: hw/rtl/pfb_ram.sv
module pfb_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/palette_framebuffer_fill.sv
// channel   dir  signals                       contents
// s_axis    in   s_tvalid s_tready s_tdata s_tuser  one bus cycle or one pixel read
// m_axis    out  m_tvalid m_tready m_tdata     palette color of a pixel read
//
// Bus cycle: ST_IDLE, then ST_PREP, then ST_FILL for each pixel of a fill run (up to 15).
// Pixel read: ST_IDLE, ST_PREP, ST_RD to the output register; one video memory port sets both.
// After reset the video memory is cleared, every pixel written to zero, with s_tready low.
// A result waiting on m_tready stalls only the next pixel read, in its last cycle.
module palette_framebuffer_fill (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // bus_select[7:0], bus_data[23:8], pixel_index[39:24]
    input  logic [pfb_pkg::S_TDATA_W-1:0]  s_tdata,
    // operation[0]
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // red[7:0], green[15:8], blue[23:16]
    output logic [pfb_pkg::M_TDATA_W-1:0]  m_tdata
);

    import pfb_pkg::*;

    state_t          state_reg, state_next;
    logic            phase_reg, phase_next;
    pix_addr_t       start_reg, start_next;
    pix_addr_t       addr_reg, addr_next;
    logic [RUN_W-1:0] run_cnt_reg, run_cnt_next;
    logic            m_tvalid_reg, m_tvalid_next;

    logic            op_reg, op_next;
    logic [7:0]      sel_reg, sel_next;
    logic [15:0]     data_reg, data_next;
    logic [15:0]     pix_reg, pix_next;
    pix_t            color_reg, color_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic            ram_en;
    logic            ram_we;
    pix_addr_t       ram_addr;
    pix_t            ram_wdata;
    pix_t            ram_rdata;
    rgb_t            rgb;

    pfb_ram #(
        .WIDTH (PIX_W),
        .DEPTH (PIXEL_COUNT)
    ) u_vram (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign rgb      = PALETTE[ram_rdata];
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb
    begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        start_next    = start_reg;
        addr_next     = addr_reg;
        run_cnt_next  = run_cnt_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        op_next       = op_reg;
        sel_next      = sel_reg;
        data_next     = data_reg;
        pix_next      = pix_reg;
        color_next    = color_reg;
        m_tdata_next  = m_tdata_reg;
        ram_en        = 1'b0;
        ram_we        = 1'b0;
        ram_addr      = addr_reg;
        ram_wdata     = color_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_en    = 1'b1;
                ram_we    = 1'b1;
                ram_wdata = '0;
                addr_next = next_addr(addr_reg);
                if (addr_reg == ADDR_W'(PIXEL_COUNT - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next    = s_tuser;
                    sel_next   = s_tdata[7:0];
                    data_next  = s_tdata[23:8];
                    pix_next   = s_tdata[39:24];
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                if (op_reg)
                begin
                    ram_en     = 1'b1;
                    ram_addr   = reduce_addr(pix_reg);
                    state_next = ST_RD;
                end
                else if (sel_reg != DEV_SEL_CODE)
                begin
                    state_next = ST_IDLE;
                end
                else if (!phase_reg)
                begin
                    start_next = reduce_addr(data_reg);
                    phase_next = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    phase_next   = 1'b0;
                    run_cnt_next = data_reg[RUN_W-1:0];
                    color_next   = data_reg[COLOR_SHIFT +: PIX_W];
                    addr_next    = start_reg;
                    state_next   = (data_reg[RUN_W-1:0] == '0) ? ST_IDLE : ST_FILL;
                end
            end
            ST_FILL:
            begin
                ram_en       = 1'b1;
                ram_we       = 1'b1;
                addr_next    = next_addr(addr_reg);
                run_cnt_next = run_cnt_reg - 1'b1;
                if (run_cnt_reg == RUN_W'(1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RD:
            begin
                // read data stays put until the output register frees up
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {rgb[7:0], rgb[15:8], rgb[23:16]};
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            phase_reg    <= 1'b0;
            start_reg    <= '0;
            addr_reg     <= '0;
            run_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            start_reg    <= start_next;
            addr_reg     <= addr_next;
            run_cnt_reg  <= run_cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        sel_reg     <= sel_next;
        data_reg    <= data_next;
        pix_reg     <= pix_next;
        color_reg   <= color_next;
        m_tdata_reg <= m_tdata_next;
    end

`ifndef ASSERT_OFF
    a_read_reaches_rd: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser) |-> ##2 (state_reg == ST_RD))
        else $error("pixel read did not reach the read-data state");

    a_read_keeps_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser) |-> ##2 (phase_reg == $past(phase_reg)))
        else $error("pixel read changed the bus phase");

    a_fill_count_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FILL) |-> (run_cnt_reg != '0))
        else $error("fill state entered with an empty run");

    a_result_from_read: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_RD))
        else $error("result raised outside a pixel read");

    a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> (!m_tvalid_reg && !s_tready))
        else $error("traffic during the clearing pass");
`endif

endmodule

// File: test/tb_palette_framebuffer_fill.sv
`timescale 1ns / 100ps

module tb_palette_framebuffer_fill;

    import pfb_pkg::*;

    typedef enum bit
    {
        OP_BUS  = 1'b0,
        OP_READ = 1'b1
    } op_e;

    typedef struct packed
    {
        op_e         op;
        logic [7:0]  sel;
        logic [15:0] data;
        logic [15:0] pix;
        bit          fixed;
        rgb_t        rgb;
    } dir_row_t;

    localparam int DIR_ROWS    = 23;
    localparam int RAND_ITEMS  = 1800;
    localparam int HOLD_CYCLES = 400;

    // 0xRRGGBB per color index
    localparam rgb_t COLOR_TABLE [16] = '{
        24'h000000, 24'h444444, 24'h000088, 24'h4444BB,
        24'h008800, 24'h44BB44, 24'h008888, 24'h44BBBB,
        24'h880000, 24'hBB4444, 24'h880088, 24'hBB44BB,
        24'h888800, 24'hBB44BB, 24'h888888, 24'hBBBBBB
    };

    // expected color typed in only where it is obvious; bus rows give no result
    localparam dir_row_t PLAN [DIR_ROWS] = '{
        '{OP_READ, 8'h00, 16'h0000, 16'h0000, 1'b1, 24'h000000},
        '{OP_READ, 8'h00, 16'h0000, 16'hFFFF, 1'b1, 24'h000000},
        '{OP_BUS,  8'h03, 16'hFFFF, 16'h1234, 1'b0, 24'h000000},
        '{OP_BUS,  8'h02, 16'hFFFA, 16'hFFFF, 1'b0, 24'h000000},
        '{OP_BUS,  8'h00, 16'h0000, 16'h0000, 1'b0, 24'h000000},
        '{OP_BUS,  8'h02, 16'hF00F, 16'h0000, 1'b0, 24'h000000},
        '{OP_READ, 8'hFF, 16'hFFFF, 16'hFFFA, 1'b1, 24'hBBBBBB},
        '{OP_READ, 8'h00, 16'h0000, 16'h0008, 1'b1, 24'hBBBBBB},
        '{OP_READ, 8'h00, 16'h0000, 16'h0009, 1'b1, 24'h000000},
        '{OP_BUS,  8'hFF, 16'h0000, 16'h0000, 1'b0, 24'h000000},
        '{OP_BUS,  8'h02, 16'h0000, 16'hFFFF, 1'b0, 24'h000000},
        '{OP_BUS,  8'h02, 16'hD000, 16'h0000, 1'b0, 24'h000000},
        '{OP_READ, 8'h00, 16'h0000, 16'h0000, 1'b1, 24'hBBBBBB},
        '{OP_BUS,  8'h02, 16'h0100, 16'h0000, 1'b0, 24'h000000},
        '{OP_BUS,  8'h02, 16'hB001, 16'h0000, 1'b0, 24'h000000},
        '{OP_BUS,  8'h02, 16'h0101, 16'h0000, 1'b0, 24'h000000},
        '{OP_BUS,  8'h02, 16'hD002, 16'h0000, 1'b0, 24'h000000},
        '{OP_READ, 8'h02, 16'h8000, 16'h0100, 1'b1, 24'hBB44BB},
        '{OP_READ, 8'h00, 16'h0000, 16'h0101, 1'b1, 24'hBB44BB},
        '{OP_BUS,  8'h02, 16'h8000, 16'h0000, 1'b0, 24'h000000},
        '{OP_BUS,  8'h02, 16'h1003, 16'h0000, 1'b0, 24'h000000},
        '{OP_READ, 8'h00, 16'h0000, 16'h8002, 1'b1, 24'h444444},
        '{OP_READ, 8'h00, 16'h0000, 16'h8003, 1'b1, 24'h000000}
    };

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;

    // shadow of the device
    bit          phase_odd_q;
    logic [15:0] fill_base;
    logic [3:0]  vmem [PIXEL_COUNT];

    rgb_t rgb_expected [$];
    int   errors;
    int   n_reads;
    int   n_addr;
    int   n_fill;
    int   n_foreign;
    bit   quiet;
    bit   hold_req;

    palette_framebuffer_fill uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("%0t: timeout", $time);
        $display("Some tests failed");
        $finish;
    end

    // updates the shadow state for one transaction, returns the color of a read
    task automatic fb_apply(input op_e op, input logic [7:0] sel, input logic [15:0] data,
                            input logic [15:0] pix, output rgb_t rgb, output bit has_rgb);
        has_rgb = 1'b0;
        rgb     = '0;
        if (op == OP_READ)
        begin
            rgb     = COLOR_TABLE[vmem[int'(pix) % PIXEL_COUNT]];
            has_rgb = 1'b1;
            n_reads++;
        end
        else if (sel != DEV_SEL_CODE)
        begin
            n_foreign++;
        end
        else
        begin
            if (!phase_odd_q)
            begin
                fill_base = data;
                n_addr++;
            end
            else
            begin
                // run wraps at the end of video memory
                for (int i = 0; i < int'(data[3:0]); i++)
                begin
                    vmem[(int'(fill_base) + i) % PIXEL_COUNT] = data[15:12];
                end
                n_fill++;
            end
            phase_odd_q = ~phase_odd_q;
        end
    endtask

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_item(input op_e op, input logic [7:0] sel, input logic [15:0] data,
                             input logic [15:0] pix, input bit fixed, input rgb_t fixed_rgb);
        rgb_t rgb;
        bit   has_rgb;
        if (!quiet && $urandom_range(0, 99) < 10)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {pix, data, sel};
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        fb_apply(op, sel, data, pix, rgb, has_rgb);
        if (has_rgb)
        begin
            rgb_expected.push_back(fixed ? fixed_rgb : rgb);
        end
        @(negedge clk);
    endtask

    // receiver: random stalls, one long hold-off on request
    initial
    begin
        int hold_left;
        bit hold_taken;
        hold_left  = 0;
        hold_taken = 1'b0;
        m_tready   = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else if (hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES - 1;
                m_tready  <= 1'b0;
            end
            else
            begin
                m_tready <= quiet || ($urandom_range(0, 99) >= 10);
            end
        end
    end

    always @(posedge clk)
    begin
        rgb_t        want;
        logic [23:0] want_bus;
        string       names [3];
        names = '{"red", "green", "blue"};
        if (rst_n && m_tvalid && m_tready)
        begin
            if (rgb_expected.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got %h", $time, m_tdata);
                errors++;
            end
            else
            begin
                want     = rgb_expected.pop_front();
                want_bus = {want[7:0], want[15:8], want[23:16]};
                for (int f = 0; f < 3; f++)
                begin
                    if (m_tdata[f*8 +: 8] !== want_bus[f*8 +: 8])
                    begin
                        $display("%0t: %s mismatch, expected %h, got %h", $time, names[f],
                                 want_bus[f*8 +: 8], m_tdata[f*8 +: 8]);
                        errors++;
                    end
                end
            end
        end
    end

    initial
    begin
        int          counted;
        int          roll;
        int          hot_wr;
        int          forced;
        bit          hold_done;
        logic [15:0] hot [8];
        op_e         op;
        logic [7:0]  sel;
        logic [15:0] data;
        logic [15:0] pix;

        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = 1'b0;
        errors      = 0;
        n_reads     = 0;
        n_addr      = 0;
        n_fill      = 0;
        n_foreign   = 0;
        quiet       = 1'b0;
        hold_req    = 1'b0;
        phase_odd_q = 1'b0;
        fill_base   = '0;
        for (int i = 0; i < PIXEL_COUNT; i++)
        begin
            vmem[i] = '0;
        end
        for (int i = 0; i < 8; i++)
        begin
            hot[i] = '0;
        end
        hot_wr    = 0;
        forced    = 0;
        hold_done = 1'b0;
        counted   = 0;

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // first transaction waits out the clearing pass on s_tready
        for (int r = 0; r < DIR_ROWS; r++)
        begin
            send_item(PLAN[r].op, PLAN[r].sel, PLAN[r].data, PLAN[r].pix,
                      PLAN[r].fixed, PLAN[r].rgb);
        end

        while (counted < RAND_ITEMS)
        begin
            quiet = (counted >= 1000 && counted < 1250);
            if (counted >= 600 && !hold_done)
            begin
                // reads back to back while the output is held, so the input stalls
                hold_done = 1'b1;
                hold_req  = 1'b1;
                forced    = 30;
            end
            roll = $urandom_range(0, 99);
            sel  = DEV_SEL_CODE;
            data = 16'($urandom);
            pix  = 16'($urandom);
            if (forced > 0 || roll < 40)
            begin
                op  = OP_READ;
                sel = 8'($urandom);
                if ($urandom_range(0, 99) < 70)
                begin
                    pix = hot[$urandom_range(0, 7)] + 16'($urandom_range(0, 16));
                end
                if (forced > 0)
                begin
                    forced--;
                end
            end
            else if (roll < 85)
            begin
                op = OP_BUS;
                if (!phase_odd_q)
                begin
                    if ($urandom_range(0, 99) < 15)
                    begin
                        data = 16'hFFF0 | 16'($urandom_range(0, 15));
                    end
                    hot[hot_wr] = data;
                    hot_wr      = (hot_wr + 1) % 8;
                end
            end
            else
            begin
                op  = OP_BUS;
                sel = 8'($urandom);
                if (sel == DEV_SEL_CODE)
                begin
                    sel = ~sel;
                end
            end
            counted++;
            send_item(op, sel, data, pix, 1'b0, '0);
        end

        quiet = 1'b0;
        s_tvalid <= 1'b0;
        while (rgb_expected.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (40) @(posedge clk);

        $display("Covered %0d pixel reads, %0d address and %0d fill cycles, %0d foreign selects",
                 n_reads, n_addr, n_fill, n_foreign);
        $display("Runs 0-15 with address wrap, interleaved reads, stalls and a long output hold");
        if (errors == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
